FILE: hdl/arpc_pkg.sv
// shared types and constants of the arp cache and responder
package arpc_pkg;

    localparam int MAC_W = 48;
    localparam int IP_W  = 32;
    localparam int ENTRY_W = IP_W + MAC_W;

    localparam logic [15:0] OP_REQUEST  = 16'h0001;
    localparam logic [15:0] OP_REPLY    = 16'h0002;
    localparam logic [15:0] HW_ETHERNET = 16'h0001;
    localparam logic [15:0] PROTO_IPV4  = 16'h0800;
    localparam logic [7:0]  MAC_LEN     = 8'd6;
    localparam logic [7:0]  IP_LEN      = 8'd4;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_BAD_OPCODE = 2'd2;
    localparam logic [1:0] ST_FULL       = 2'd3;

    localparam int IN_DATA_W  = 224;
    localparam int OUT_DATA_W = 136;

    typedef struct packed {
        logic             start;
        logic             store;
        logic [IP_W-1:0]  ip;
        logic [MAC_W-1:0] mac;
    } t_tbl_cmd;

    typedef struct packed {
        logic             idle;
        logic             done;
        logic             hit;
        logic             full;
        logic [MAC_W-1:0] mac;
    } t_tbl_sts;

    typedef struct packed {
        logic             wake_waiters;
        logic [IP_W-1:0]  reply_target_ip;
        logic [MAC_W-1:0] reply_dst_mac;
        logic             send_reply;
        logic [MAC_W-1:0] found_mac;
        logic             hit;
        logic [1:0]       status;
    } t_result;

endpackage

FILE: hdl/arpc_table.sv
// arp table memory with valid bits and the entry walk for store and lookup
module arpc_table #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  arpc_pkg::t_tbl_cmd i_cmd,
    output arpc_pkg::t_tbl_sts o_sts
);

    localparam int IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

    typedef enum logic [1:0] {S_IDLE, S_WALK, S_UPDATE} t_state;

    logic [arpc_pkg::ENTRY_W-1:0] mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0]       r_valid;

    t_state                       r_state;
    logic                         r_store;
    logic [arpc_pkg::IP_W-1:0]    r_key_ip;
    logic [arpc_pkg::MAC_W-1:0]   r_key_mac;
    logic [IW-1:0]                r_addr;
    logic                         r_issue;
    logic                         r_cmp_vld;
    logic [IW-1:0]                r_cmp_idx;
    logic                         r_cmp_last;
    logic [arpc_pkg::ENTRY_W-1:0] r_rdata;
    logic                         r_match;
    logic [IW-1:0]                r_match_idx;
    logic [arpc_pkg::MAC_W-1:0]   r_match_mac;
    logic                         r_free;
    logic [IW-1:0]                r_free_idx;
    logic                         r_done;
    logic                         r_hit;
    logic                         r_full;
    logic [arpc_pkg::MAC_W-1:0]   r_mac_out;

    logic                         cmp_entry_valid;
    logic                         hit_now;
    logic                         free_now;
    logic                         wr_en;
    logic [IW-1:0]                wr_idx;

    assign cmp_entry_valid = r_valid[r_cmp_idx];
    assign hit_now  = r_cmp_vld && cmp_entry_valid &&
                      (r_rdata[arpc_pkg::ENTRY_W-1:arpc_pkg::MAC_W] == r_key_ip);
    assign free_now = r_cmp_vld && !cmp_entry_valid;
    assign wr_en    = (r_state == S_UPDATE) && r_store && (r_match || r_free);
    assign wr_idx   = r_match ? r_match_idx : r_free_idx;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_idx] <= {r_key_ip, r_key_mac};
        end
        if (r_issue) begin
            r_rdata <= mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_valid   <= '0;
            r_issue   <= 1'b0;
            r_cmp_vld <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_done     <= 1'b0;
            r_cmp_vld  <= r_issue;
            r_cmp_idx  <= r_addr;
            r_cmp_last <= (r_addr == LAST_IDX);
            unique case (r_state)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_store   <= i_cmd.store;
                        r_key_ip  <= i_cmd.ip;
                        r_key_mac <= i_cmd.mac;
                        r_addr    <= '0;
                        r_issue   <= 1'b1;
                        r_match   <= 1'b0;
                        r_free    <= 1'b0;
                        r_state   <= S_WALK;
                    end
                end
                S_WALK: begin
                    if (r_issue) begin
                        if (r_addr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + IW'(1);
                        end
                    end
                    if (hit_now && !r_match) begin
                        r_match     <= 1'b1;
                        r_match_idx <= r_cmp_idx;
                        r_match_mac <= r_rdata[arpc_pkg::MAC_W-1:0];
                    end
                    if (free_now && !r_free) begin
                        r_free     <= 1'b1;
                        r_free_idx <= r_cmp_idx;
                    end
                    if (r_cmp_vld && r_cmp_last) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_done    <= 1'b1;
                    r_hit     <= r_match;
                    r_mac_out <= r_match ? r_match_mac : '0;
                    r_full    <= r_store && !r_match && !r_free;
                    if (wr_en && !r_match) begin
                        r_valid[r_free_idx] <= 1'b1;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_sts.idle = (r_state == S_IDLE);
    assign o_sts.done = r_done;
    assign o_sts.hit  = r_hit;
    assign o_sts.full = r_full;
    assign o_sts.mac  = r_mac_out;

endmodule

FILE: hdl/arp_cache_and_responder_unit.sv
// arp cache and responder top level: packet decode, sequencing, config and result register
//
// One result beat comes out for every input beat. The table lives in a single-port
// synchronous memory that is walked one entry per cycle. A lookup or an ARP request
// makes one walk of the table, an ARP reply two (sender pair then target pair), and a
// bad header or unknown opcode none. The next beat is taken once the previous result sits
// in the output register. Valid bits are flip-flops cleared by reset, so no clearing
// pass is needed.
// Registers: local_ip at byte address 0, local_mac at byte address 8.
module arp_cache_and_responder_unit #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata: opcode, hw_type, proto_type, hw_len, proto_len, sender_mac, src_ip,
    // target_mac, target_ip
    input  logic [arpc_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: cmd
    input  logic                               s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata: status, hit, found_mac, send_reply, reply_dst_mac, reply_target_ip,
    // wake_waiters, zero pad
    output logic [arpc_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [3:0]                         paddr,
    input  logic [63:0]                        pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);

    localparam logic REG_LOCAL_IP  = 1'b0;
    localparam logic REG_LOCAL_MAC = 1'b1;
    localparam int   PAD_W = arpc_pkg::OUT_DATA_W - $bits(arpc_pkg::t_result);

    typedef enum logic [1:0] {S_IDLE, S_WAIT, S_DONE} t_state;

    logic [arpc_pkg::IP_W-1:0]  r_local_ip;
    logic [arpc_pkg::MAC_W-1:0] r_local_mac;

    t_state                     r_state;
    arpc_pkg::t_tbl_cmd         r_cmd;
    arpc_pkg::t_tbl_sts         tbl_sts;
    logic                       r_lookup;
    logic                       r_reply;
    logic [arpc_pkg::IP_W-1:0]  r_t_ip;
    logic [arpc_pkg::MAC_W-1:0] r_t_mac;
    arpc_pkg::t_result          r_res;
    arpc_pkg::t_result          r_out;
    logic                       r_out_valid;

    logic                       in_cmd;
    logic [15:0]                in_opcode;
    logic [15:0]                in_hw_type;
    logic [15:0]                in_proto_type;
    logic [7:0]                 in_hw_len;
    logic [7:0]                 in_proto_len;
    logic [arpc_pkg::MAC_W-1:0] in_sender_mac;
    logic [arpc_pkg::IP_W-1:0]  in_src_ip;
    logic [arpc_pkg::MAC_W-1:0] in_target_mac;
    logic [arpc_pkg::IP_W-1:0]  in_target_ip;
    logic                       hdr_ok;
    logic                       in_beat;
    logic                       cfg_wr;

    assign in_cmd        = s_axis_tuser;
    assign in_opcode     = s_axis_tdata[15:0];
    assign in_hw_type    = s_axis_tdata[31:16];
    assign in_proto_type = s_axis_tdata[47:32];
    assign in_hw_len     = s_axis_tdata[55:48];
    assign in_proto_len  = s_axis_tdata[63:56];
    assign in_sender_mac = s_axis_tdata[111:64];
    assign in_src_ip     = s_axis_tdata[143:112];
    assign in_target_mac = s_axis_tdata[191:144];
    assign in_target_ip  = s_axis_tdata[223:192];

    assign hdr_ok = (in_hw_type == arpc_pkg::HW_ETHERNET) &&
                    (in_proto_type == arpc_pkg::PROTO_IPV4) &&
                    (in_hw_len == arpc_pkg::MAC_LEN) &&
                    (in_proto_len == arpc_pkg::IP_LEN);

    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // config port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_local_ip  <= '0;
            r_local_mac <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[3])
                REG_LOCAL_IP:  r_local_ip  <= pwdata[arpc_pkg::IP_W-1:0];
                REG_LOCAL_MAC: r_local_mac <= pwdata[arpc_pkg::MAC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3])
            REG_LOCAL_IP:  prdata = {32'd0, r_local_ip};
            REG_LOCAL_MAC: prdata = {16'd0, r_local_mac};
            default:       prdata = '0;
        endcase
    end

    arpc_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cmd  (r_cmd),
        .o_sts  (tbl_sts)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd.start <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_cmd.start <= 1'b0;
            if (r_out_valid && m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_beat) begin
                        r_res    <= '0;
                        r_lookup <= in_cmd;
                        r_reply  <= 1'b0;
                        r_t_ip   <= in_target_ip;
                        r_t_mac  <= in_target_mac;
                        if (in_cmd) begin
                            r_cmd.start <= 1'b1;
                            r_cmd.store <= 1'b0;
                            r_cmd.ip    <= in_target_ip;
                            r_cmd.mac   <= in_target_mac;
                            r_state     <= S_WAIT;
                        end else if (!hdr_ok) begin
                            r_res.status <= arpc_pkg::ST_BAD_HEADER;
                            r_state      <= S_DONE;
                        end else if (in_opcode == arpc_pkg::OP_REPLY ||
                                     in_opcode == arpc_pkg::OP_REQUEST) begin
                            r_cmd.start <= 1'b1;
                            r_cmd.store <= 1'b1;
                            r_cmd.ip    <= in_src_ip;
                            r_cmd.mac   <= in_sender_mac;
                            r_state     <= S_WAIT;
                            if (in_opcode == arpc_pkg::OP_REPLY) begin
                                r_reply            <= 1'b1;
                                r_res.wake_waiters <= 1'b1;
                            end else if (in_target_ip == r_local_ip) begin
                                r_res.send_reply      <= 1'b1;
                                r_res.reply_dst_mac   <= in_sender_mac;
                                r_res.reply_target_ip <= in_src_ip;
                            end
                        end else begin
                            r_res.status <= arpc_pkg::ST_BAD_OPCODE;
                            r_state      <= S_DONE;
                        end
                    end
                end
                S_WAIT: begin
                    if (tbl_sts.done) begin
                        if (r_lookup) begin
                            r_res.hit       <= tbl_sts.hit;
                            r_res.found_mac <= tbl_sts.mac;
                            r_state         <= S_DONE;
                        end else begin
                            if (tbl_sts.full) begin
                                r_res.status <= arpc_pkg::ST_FULL;
                            end
                            if (r_reply) begin
                                // second pass stores the target pair
                                r_reply     <= 1'b0;
                                r_cmd.start <= 1'b1;
                                r_cmd.store <= 1'b1;
                                r_cmd.ip    <= r_t_ip;
                                r_cmd.mac   <= r_t_mac;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_out};

    a_start_when_table_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cmd.start |-> tbl_sts.idle)
        else $error("table started while busy");

    a_done_only_when_waiting: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        tbl_sts.done |-> (r_state == S_WAIT))
        else $error("table finished with no job pending");

    a_one_beat_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_beat |=> !s_axis_tready)
        else $error("input taken while a job is in flight");

    a_wake_only_on_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.wake_waiters) |->
        (r_out.status == arpc_pkg::ST_OK || r_out.status == arpc_pkg::ST_FULL))
        else $error("wake on a dropped packet");

    a_hit_only_on_lookup: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.hit) |->
        (r_out.status == arpc_pkg::ST_OK && !r_out.send_reply && !r_out.wake_waiters))
        else $error("hit flagged on a receive beat");

endmodule

FILE: bench/arp_cache_and_responder_unit_test.sv
`timescale 1ns / 1ps
// self-checking stream bench for the arp cache and responder, with its own table predictor
module arp_cache_and_responder_unit_test;

    localparam int DEPTH = 16;
    localparam int POOL_SIZE = 40;
    localparam int PHASES = 6;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int STALL_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 60;

    localparam logic CMD_RECEIVE = 1'b0;
    localparam logic CMD_LOOKUP  = 1'b1;

    localparam logic [3:0] REG_LOCAL_IP  = 4'h0;
    localparam logic [3:0] REG_LOCAL_MAC = 4'h8;

    localparam logic [arpc_pkg::IP_W-1:0] HOST_IP = 32'h0a00_0001;

    typedef struct packed {
        logic [arpc_pkg::IP_W-1:0]  target_ip;
        logic [arpc_pkg::MAC_W-1:0] target_mac;
        logic [arpc_pkg::IP_W-1:0]  src_ip;
        logic [arpc_pkg::MAC_W-1:0] sender_mac;
        logic [7:0]                 proto_len;
        logic [7:0]                 hw_len;
        logic [15:0]                proto_type;
        logic [15:0]                hw_type;
        logic [15:0]                opcode;
    } t_arp_fields;

    typedef struct packed {
        logic        cmd;
        t_arp_fields f;
    } t_arp_beat;

    typedef struct {
        t_arp_beat  beat;
        bit         fixed;
        logic [1:0] status;
    } t_dir_row;

    typedef enum int {K_REQUEST, K_REPLY, K_LOOKUP, K_NOISE} t_beat_kind;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_axis_tready;
    // fields from bit 0 up: opcode, hw_type, proto_type, hw_len, proto_len, sender_mac,
    // src_ip, target_mac, target_ip
    logic [arpc_pkg::IN_DATA_W-1:0]  s_tdata = '0;
    // cmd
    logic                            s_tuser = 1'b0;
    logic                            m_axis_tvalid;
    logic                            m_tready = 1'b0;
    // fields from bit 0 up: status, hit, found_mac, send_reply, reply_dst_mac,
    // reply_target_ip, wake_waiters, zero pad
    logic [arpc_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [3:0]                      paddr = '0;
    logic [63:0]                     pwdata = '0;
    logic [63:0]                     prdata;
    logic                            pready;

    bit                         tbl_valid [DEPTH];
    logic [arpc_pkg::IP_W-1:0]  tbl_ip [DEPTH];
    logic [arpc_pkg::MAC_W-1:0] tbl_mac [DEPTH];
    logic [arpc_pkg::IP_W-1:0]  my_ip = '0;

    arpc_pkg::t_result          pending_results[$];
    t_dir_row                   dir_rows[$];
    logic [arpc_pkg::IP_W-1:0]  ip_pool [POOL_SIZE];
    int                         pool_used = 8;
    int                         in_idle_pct = 30;
    int                         out_idle_pct = 30;
    int                         mismatch_count = 0;
    int                         quiet_cycles = 0;

    arp_cache_and_responder_unit #(.TABLE_DEPTH(DEPTH)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit learn_pair(logic [arpc_pkg::MAC_W-1:0] mac,
                                      logic [arpc_pkg::IP_W-1:0] ip);
        for (int i = 0; i < DEPTH; i++) begin
            if (tbl_valid[i] && tbl_ip[i] == ip) begin
                tbl_mac[i] = mac;
                return 1'b1;
            end
        end
        for (int i = 0; i < DEPTH; i++) begin
            if (!tbl_valid[i]) begin
                tbl_valid[i] = 1'b1;
                tbl_ip[i] = ip;
                tbl_mac[i] = mac;
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic arpc_pkg::t_result resolve_arp(t_arp_beat b);
        arpc_pkg::t_result r;
        bit                sender_ok;
        bit                target_ok;
        r = '0;
        if (b.cmd == CMD_LOOKUP) begin
            for (int i = 0; i < DEPTH; i++) begin
                if (tbl_valid[i] && tbl_ip[i] == b.f.target_ip) begin
                    r.hit = 1'b1;
                    r.found_mac = tbl_mac[i];
                    break;
                end
            end
        end else if (b.f.hw_type != arpc_pkg::HW_ETHERNET ||
                     b.f.proto_type != arpc_pkg::PROTO_IPV4 ||
                     b.f.hw_len != arpc_pkg::MAC_LEN ||
                     b.f.proto_len != arpc_pkg::IP_LEN) begin
            r.status = arpc_pkg::ST_BAD_HEADER;
        end else if (b.f.opcode == arpc_pkg::OP_REPLY) begin
            sender_ok = learn_pair(b.f.sender_mac, b.f.src_ip);
            target_ok = learn_pair(b.f.target_mac, b.f.target_ip);
            r.status = (sender_ok && target_ok) ? arpc_pkg::ST_OK : arpc_pkg::ST_FULL;
            r.wake_waiters = 1'b1;
        end else if (b.f.opcode == arpc_pkg::OP_REQUEST) begin
            r.status = learn_pair(b.f.sender_mac, b.f.src_ip) ? arpc_pkg::ST_OK
                                                               : arpc_pkg::ST_FULL;
            if (b.f.target_ip == my_ip) begin
                r.send_reply = 1'b1;
                r.reply_dst_mac = b.f.sender_mac;
                r.reply_target_ip = b.f.src_ip;
            end
        end else begin
            r.status = arpc_pkg::ST_BAD_OPCODE;
        end
        return r;
    endfunction

    function automatic t_arp_beat mk_beat(logic cmd, logic [15:0] op,
                                          logic [arpc_pkg::MAC_W-1:0] smac,
                                          logic [arpc_pkg::IP_W-1:0] sip,
                                          logic [arpc_pkg::MAC_W-1:0] tmac,
                                          logic [arpc_pkg::IP_W-1:0] tip);
        t_arp_beat b;
        b.cmd = cmd;
        b.f.opcode = op;
        b.f.hw_type = arpc_pkg::HW_ETHERNET;
        b.f.proto_type = arpc_pkg::PROTO_IPV4;
        b.f.hw_len = arpc_pkg::MAC_LEN;
        b.f.proto_len = arpc_pkg::IP_LEN;
        b.f.sender_mac = smac;
        b.f.src_ip = sip;
        b.f.target_mac = tmac;
        b.f.target_ip = tip;
        return b;
    endfunction

    function automatic logic [arpc_pkg::MAC_W-1:0] rand_mac();
        case ($urandom_range(9))
            0: return '0;
            1: return '1;
            default: return {16'($urandom), $urandom};
        endcase
    endfunction

    function automatic logic [arpc_pkg::IP_W-1:0] pool_ip();
        return ip_pool[$urandom_range(pool_used - 1)];
    endfunction

    function automatic t_arp_beat rand_beat();
        t_arp_beat  b;
        t_beat_kind kind;
        int         roll;
        roll = $urandom_range(99);
        kind = (roll < 35) ? K_REQUEST : (roll < 65) ? K_REPLY : (roll < 90) ? K_LOOKUP : K_NOISE;
        case (kind)
            K_REQUEST: b = mk_beat(CMD_RECEIVE, arpc_pkg::OP_REQUEST, rand_mac(), pool_ip(),
                                   rand_mac(), ($urandom_range(99) < 30) ? my_ip : pool_ip());
            K_REPLY:   b = mk_beat(CMD_RECEIVE, arpc_pkg::OP_REPLY, rand_mac(), pool_ip(),
                                   rand_mac(), pool_ip());
            K_LOOKUP:  b = mk_beat(CMD_LOOKUP, 16'($urandom), rand_mac(), $urandom, rand_mac(),
                                   ($urandom_range(99) < 20) ? $urandom : pool_ip());
            default: begin
                b.cmd = 1'($urandom);
                b.f.opcode = 16'($urandom);
                b.f.hw_type = 16'($urandom);
                b.f.proto_type = 16'($urandom);
                b.f.hw_len = 8'($urandom);
                b.f.proto_len = 8'($urandom);
                b.f.sender_mac = rand_mac();
                b.f.src_ip = $urandom;
                b.f.target_mac = rand_mac();
                b.f.target_ip = $urandom;
                if ($urandom_range(1)) begin
                    b = mk_beat(CMD_RECEIVE, b.f.opcode, b.f.sender_mac, b.f.src_ip,
                                b.f.target_mac, b.f.target_ip);
                end
            end
        endcase
        return b;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("%0t mismatch %s: got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_beat(t_arp_beat b, bit fixed, logic [1:0] fixed_status);
        arpc_pkg::t_result predicted;
        while ($urandom_range(99) < in_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= b.f;
        s_tuser <= b.cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        predicted = resolve_arp(b);
        if (fixed) begin
            predicted = '0;
            predicted.status = fixed_status;
        end
        pending_results.push_back(predicted);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    task automatic write_reg(logic [3:0] addr, logic [63:0] value);
        wait_drained();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (addr == REG_LOCAL_IP) begin
            my_ip = value[arpc_pkg::IP_W-1:0];
        end
    endtask

    task automatic set_host(logic [arpc_pkg::IP_W-1:0] ip, logic [arpc_pkg::MAC_W-1:0] mac);
        write_reg(REG_LOCAL_IP, 64'(ip));
        write_reg(REG_LOCAL_MAC, 64'(mac));
    endtask

    always @(posedge i_clk) begin : result_check
        arpc_pkg::t_result got;
        arpc_pkg::t_result want;
        if (i_rst_n && m_axis_tvalid && m_tready) begin
            got = arpc_pkg::t_result'(m_axis_tdata[$bits(arpc_pkg::t_result)-1:0]);
            if (pending_results.size() == 0) begin
                report_mismatch("beat with nothing pending", m_axis_tdata[63:0], '0);
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                if (got.hit !== want.hit)
                    report_mismatch("hit", 64'(got.hit), 64'(want.hit));
                if (got.found_mac !== want.found_mac)
                    report_mismatch("found_mac", 64'(got.found_mac), 64'(want.found_mac));
                if (got.send_reply !== want.send_reply)
                    report_mismatch("send_reply", 64'(got.send_reply), 64'(want.send_reply));
                if (got.reply_dst_mac !== want.reply_dst_mac)
                    report_mismatch("reply_dst_mac", 64'(got.reply_dst_mac),
                                    64'(want.reply_dst_mac));
                if (got.reply_target_ip !== want.reply_target_ip)
                    report_mismatch("reply_target_ip", 64'(got.reply_target_ip),
                                    64'(want.reply_target_ip));
                if (got.wake_waiters !== want.wake_waiters)
                    report_mismatch("wake_waiters", 64'(got.wake_waiters),
                                    64'(want.wake_waiters));
            end
        end
        m_tready <= ($urandom_range(99) >= out_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((s_tvalid && s_axis_tready) || (m_axis_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("arp_cache_and_responder_unit_test: errors");
            $finish;
        end
    end

    initial begin : stimulus
        t_arp_beat ask_me;
        t_arp_beat b;

        ip_pool[0] = '0;
        ip_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) ip_pool[i] = $urandom;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        set_host(HOST_IP, 48'h0200_0000_0001);

        ask_me = mk_beat(CMD_RECEIVE, arpc_pkg::OP_REQUEST, 48'h0a0b_0c0d_0e0f, 32'h0a00_0002,
                         '0, HOST_IP);
        dir_rows.push_back('{mk_beat(CMD_LOOKUP, arpc_pkg::OP_REQUEST, '0, '0, '0, '0),
                             1'b1, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_LOOKUP, arpc_pkg::OP_REQUEST, '0, '0, '0, '1),
                             1'b1, arpc_pkg::ST_OK});
        b = ask_me; b.f.hw_type = '0;
        dir_rows.push_back('{b, 1'b1, arpc_pkg::ST_BAD_HEADER});
        b = ask_me; b.f.proto_type = '1;
        dir_rows.push_back('{b, 1'b1, arpc_pkg::ST_BAD_HEADER});
        b = ask_me; b.f.hw_len = '1;
        dir_rows.push_back('{b, 1'b1, arpc_pkg::ST_BAD_HEADER});
        b = ask_me; b.f.proto_len = '0;
        dir_rows.push_back('{b, 1'b1, arpc_pkg::ST_BAD_HEADER});
        b = ask_me; b.f.opcode = '0;
        dir_rows.push_back('{b, 1'b1, arpc_pkg::ST_BAD_OPCODE});
        b = ask_me; b.f.opcode = '1;
        dir_rows.push_back('{b, 1'b1, arpc_pkg::ST_BAD_OPCODE});
        b = ask_me; b.f.opcode = 16'h0003;
        dir_rows.push_back('{b, 1'b1, arpc_pkg::ST_BAD_OPCODE});
        dir_rows.push_back('{ask_me, 1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_RECEIVE, arpc_pkg::OP_REQUEST, '0, '0, '1, HOST_IP),
                             1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_RECEIVE, arpc_pkg::OP_REQUEST, '1, '1, '0,
                                     32'h0a00_0003), 1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_RECEIVE, arpc_pkg::OP_REPLY, 48'h1, 32'h1, 48'h2,
                                     32'h2), 1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_RECEIVE, arpc_pkg::OP_REPLY, 48'h3, 32'h3, 48'h4,
                                     32'h3), 1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_LOOKUP, arpc_pkg::OP_REQUEST, '0, '0, '0, '0),
                             1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_LOOKUP, arpc_pkg::OP_REQUEST, '0, '0, '0, '1),
                             1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_LOOKUP, arpc_pkg::OP_REQUEST, '0, '0, '0, 32'h2),
                             1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_LOOKUP, arpc_pkg::OP_REQUEST, '0, '0, '0, 32'h3),
                             1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_RECEIVE, arpc_pkg::OP_REQUEST, 48'h5, 32'h1, '0, '0),
                             1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_LOOKUP, arpc_pkg::OP_REQUEST, '0, '0, '0, 32'h1),
                             1'b0, arpc_pkg::ST_OK});
        b = mk_beat(CMD_LOOKUP, '1, '1, '1, '1, 32'h0a00_0002);
        b.f.hw_type = '1; b.f.proto_type = '1; b.f.hw_len = '1; b.f.proto_len = '1;
        dir_rows.push_back('{b, 1'b0, arpc_pkg::ST_OK});
        dir_rows.push_back('{mk_beat(CMD_LOOKUP, arpc_pkg::OP_REQUEST, '0, '0, '0,
                                     32'h0a00_0009), 1'b0, arpc_pkg::ST_OK});

        foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].status);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    set_host(ip_pool[2], rand_mac());
                    pool_used = 8;
                end
                1: set_host('1, '1);
                2: begin
                    set_host('0, '0);
                    pool_used = 12;
                end
                3: begin
                    set_host($urandom, rand_mac());
                    pool_used = POOL_SIZE;
                end
                4: begin
                    set_host(ip_pool[5], rand_mac());
                    in_idle_pct = 0;
                    out_idle_pct = 0;
                end
                default: begin
                    set_host(ip_pool[7], '1);
                    in_idle_pct = 30;
                    out_idle_pct = 30;
                end
            endcase
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // hold off until the table has answered everything sent so far
                if (p == PHASES - 1 && n == ITEMS_PER_PHASE / 2) wait_drained();
                send_beat(rand_beat(), 1'b0, arpc_pkg::ST_OK);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("arp_cache_and_responder_unit_test: clean");
        end else begin
            $display("arp_cache_and_responder_unit_test: errors");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/arpc_pkg.sv
hdl/arpc_table.sv
hdl/arp_cache_and_responder_unit.sv
bench/arp_cache_and_responder_unit_test.sv
